/* rtl/llt_pkg.sv */
package llt_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_OFFSET_PX  = 3'd2,
    REG_BASELINE   = 3'd3,
    REG_DEPTH      = 3'd4,
    REG_MM_PER_PXX = 3'd5,
    REG_MM_PER_PXY = 3'd6
  } cfg_idx_t;

  localparam int CFG_W      = 18;
  localparam int BASE_W     = 16;
  localparam int DEPTH_W    = 18;
  localparam int SCALE_W    = 16;
  localparam int ANGLE_W    = 9;
  localparam int ANGLE_N    = 512;
  localparam int TRIG_W     = 16;
  localparam int TMAG_W     = 15;
  localparam int RATIO_W    = 17;
  localparam int DR_W       = DEPTH_W + RATIO_W;
  localparam int PROD_W     = DR_W + TMAG_W;
  localparam int COORD_W    = 24;
  localparam int MAG_W      = 32;
  localparam int FRONT_STG  = 3;
  localparam int DIV_STG    = RATIO_W;
  localparam int BACK_STG   = 3;
  localparam int NUM_STG    = FRONT_STG + DIV_STG + BACK_STG;

  localparam longint unsigned TWO_PI_Q29 = 64'd3373259426;
  localparam logic [31:0]     QUARTER    = 32'h4000_0000;
  localparam logic [31:0]     HALF       = 32'h8000_0000;

  // Side data that rides along with the ratio divider
  typedef struct packed {
    logic signed [TRIG_W-1:0]  sin_q;
    logic signed [TRIG_W-1:0]  cos_q;
    logic                      dz;
    logic        [COORD_W-1:0] y_q;
  } side_t;

  // Sine of a turn fraction (Q0.32) as signed Q1.14, evaluated at elaboration
  function automatic logic signed [TRIG_W-1:0] turn_sin(input logic [31:0] fin);
    logic              neg;
    logic [31:0]       f;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   t;
    longint            s;
    longint            q;
    f   = fin;
    neg = 1'b0;
    if (f >= HALF) begin
      neg = 1'b1;
      f   = f - HALF;
    end
    if (f > QUARTER) f = HALF - f;
    x  = (64'(f) * TWO_PI_Q29) >> 31;
    x2 = (x * x) >> 30;
    t  = ((x * x2) >> 30) / 6;
    s  = longint'(x) - longint'(t);
    t  = ((t * x2) >> 30) / 20;
    s  = s + longint'(t);
    t  = ((t * x2) >> 30) / 42;
    s  = s - longint'(t);
    t  = ((t * x2) >> 30) / 72;
    s  = s + longint'(t);
    if (s < 0) s = 0;
    q = (s + 32768) >>> 16;
    if (q > 16384) q = 16384;
    return neg ? -TRIG_W'(q) : TRIG_W'(q);
  endfunction

  // Signed 24-bit result from sign and magnitude, saturated; zero is +0
  function automatic logic [COORD_W-1:0] sat24(input logic neg, input logic [MAG_W-1:0] mag);
    logic [COORD_W-1:0] r;
    if (mag == '0) begin
      r = '0;
    end else if (neg) begin
      if (mag > 32'd8388608) r = 24'h80_0000;
      else r = COORD_W'(-mag);
    end else begin
      if (mag > 32'd8388607) r = 24'h7F_FFFF;
      else r = COORD_W'(mag);
    end
    return r;
  endfunction

endpackage

/* rtl/llt_front.sv */
module llt_front #(
  parameter int ANGLE_STEPS = 360,
  parameter int COORD_BITS  = 12
) (
  input  logic                         clk,
  input  logic [2:0]                   ld,
  input  logic [COORD_BITS-1:0]        px_x,
  input  logic [COORD_BITS-1:0]        px_y,
  input  logic [8:0]                   angle_deg,
  input  logic [COORD_BITS-1:0]        center_x,
  input  logic [COORD_BITS-1:0]        center_y,
  input  logic [COORD_BITS-1:0]        offset_px,
  input  logic [15:0]                  baseline_mm_q,
  input  logic [15:0]                  mm_per_px_x,
  input  logic [15:0]                  mm_per_px_y,
  output logic [COORD_BITS+15:0]       diff_mm,
  output logic [COORD_BITS+16:0]       den,
  output llt_pkg::side_t               side
);
  import llt_pkg::*;

  localparam int DM_W  = COORD_BITS + SCALE_W;
  localparam int DEN_W = DM_W + 1;

  // Sine and cosine tables, indexed by the raw angle, wrapped at elaboration
  logic signed [TRIG_W-1:0] sin_tab [ANGLE_N];
  logic signed [TRIG_W-1:0] cos_tab [ANGLE_N];

  for (genvar i = 0; i < ANGLE_N; i++) begin : g_tab
    localparam int unsigned          A  = i % ANGLE_STEPS;
    localparam logic [63:0]          F  = (64'(A) << 32) / ANGLE_STEPS;
    localparam logic [31:0]          FS = F[31:0];
    localparam logic signed [TRIG_W-1:0] SV = turn_sin(FS);
    localparam logic signed [TRIG_W-1:0] CV = turn_sin(FS + QUARTER);
    assign sin_tab[i] = SV;
    assign cos_tab[i] = CV;
  end

  // Stage 0: pixel distances and trig lookup
  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] diff_nxt;
  logic [COORD_BITS-1:0] dy_nxt;
  logic                  yneg_nxt;
  logic [COORD_BITS-1:0] diff_r;
  logic [COORD_BITS-1:0] dy_r;
  logic                  yneg_r;
  logic signed [TRIG_W-1:0] sin0_r, cos0_r;

  always_comb begin
    dx       = (px_x >= center_x) ? px_x - center_x : center_x - px_x;
    diff_nxt = (dx > offset_px) ? dx - offset_px : '0;
    yneg_nxt = px_y > center_y;
    dy_nxt   = yneg_nxt ? px_y - center_y : center_y - px_y;
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      diff_r <= diff_nxt;
      dy_r   <= dy_nxt;
      yneg_r <= yneg_nxt;
      sin0_r <= sin_tab[angle_deg];
      cos0_r <= cos_tab[angle_deg];
    end
  end

  // Stage 1: scale pixels to mm
  logic [DM_W-1:0] dmm1_r;
  logic [DM_W-1:0] yp1_r;
  logic            yneg1_r;
  logic signed [TRIG_W-1:0] sin1_r, cos1_r;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      dmm1_r  <= DM_W'(diff_r) * DM_W'(mm_per_px_x);
      yp1_r   <= DM_W'(dy_r) * DM_W'(mm_per_px_y);
      yneg1_r <= yneg_r;
      sin1_r  <= sin0_r;
      cos1_r  <= cos0_r;
    end
  end

  // Stage 2: denominator, zero check, y rounding
  logic [DM_W:0]   yrnd;
  logic [DEN_W-1:0] den_nxt;
  side_t           side_nxt;
  logic [DM_W-1:0] dmm2_r;
  logic [DEN_W-1:0] den_r;
  side_t           side_r;

  always_comb begin
    yrnd           = {1'b0, yp1_r} + (DM_W+1)'(128);
    den_nxt        = DEN_W'({baseline_mm_q, 8'd0}) + DEN_W'(dmm1_r);
    side_nxt.sin_q = sin1_r;
    side_nxt.cos_q = cos1_r;
    side_nxt.dz    = (baseline_mm_q == '0) && (dmm1_r == '0);
    side_nxt.y_q   = sat24(yneg1_r, MAG_W'(yrnd[DM_W:8]));
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      dmm2_r <= dmm1_r;
      den_r  <= den_nxt;
      side_r <= side_nxt;
    end
  end

  assign diff_mm = dmm2_r;
  assign den     = den_r;
  assign side    = side_r;

endmodule

/* rtl/llt_div.sv */
module llt_div #(
  parameter int COORD_BITS = 12
) (
  input  logic                          clk,
  input  logic [llt_pkg::DIV_STG-1:0]   ld,
  input  logic [COORD_BITS+15:0]        diff_mm,
  input  logic [COORD_BITS+16:0]        den,
  input  llt_pkg::side_t                side_in,
  output logic [llt_pkg::RATIO_W-1:0]   ratio,
  output llt_pkg::side_t                side_out
);
  import llt_pkg::*;

  localparam int DM_W  = COORD_BITS + SCALE_W;
  localparam int DEN_W = DM_W + 1;

  // Restoring divider, one quotient bit per stage; remainder stays below den
  logic [DEN_W-1:0]   rem_r  [DIV_STG];
  logic [DEN_W-1:0]   den_r  [DIV_STG];
  logic [RATIO_W-1:0] quo_r  [DIV_STG];
  side_t              side_r [DIV_STG];

  // First stage: top quotient bit, set only when diff_mm equals den
  logic ge0;
  assign ge0 = DEN_W'(diff_mm) >= den;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      rem_r[0]  <= ge0 ? DEN_W'(diff_mm) - den : DEN_W'(diff_mm);
      quo_r[0]  <= RATIO_W'(ge0);
      den_r[0]  <= den;
      side_r[0] <= side_in;
    end
  end

  for (genvar k = 1; k < DIV_STG; k++) begin : g_stage
    logic [DEN_W:0] rs;
    logic           ge;
    assign rs = {rem_r[k-1], 1'b0};
    assign ge = rs >= {1'b0, den_r[k-1]};

    always_ff @(posedge clk) begin
      if (ld[k]) begin
        rem_r[k]  <= ge ? DEN_W'(rs - {1'b0, den_r[k-1]}) : rs[DEN_W-1:0];
        quo_r[k]  <= {quo_r[k-1][RATIO_W-2:0], ge};
        den_r[k]  <= den_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign ratio    = quo_r[DIV_STG-1];
  assign side_out = side_r[DIV_STG-1];

endmodule

/* rtl/llt_back.sv */
module llt_back (
  input  logic                         clk,
  input  logic [2:0]                   ld,
  input  logic [llt_pkg::RATIO_W-1:0]  ratio,
  input  llt_pkg::side_t               side_in,
  input  logic [17:0]                  depth_mm_q,
  output logic [23:0]                  x_mm_q,
  output logic [23:0]                  y_mm_q,
  output logic [23:0]                  z_mm_q,
  output logic                         div_zero
);
  import llt_pkg::*;

  // Stage 0: depth times ratio
  logic [DR_W-1:0] dr_r;
  side_t           side0_r;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      dr_r    <= DR_W'(depth_mm_q) * DR_W'(ratio);
      side0_r <= side_in;
    end
  end

  // Stage 1: times trig magnitude
  logic [TMAG_W-1:0] smag, cmag;
  logic [PROD_W-1:0] ps_r, pc_r;
  logic              xneg_r, zneg_r, dz1_r;
  logic [COORD_W-1:0] y1_r;

  always_comb begin
    smag = side0_r.sin_q[TRIG_W-1] ? TMAG_W'(-side0_r.sin_q) : TMAG_W'(side0_r.sin_q);
    cmag = side0_r.cos_q[TRIG_W-1] ? TMAG_W'(-side0_r.cos_q) : TMAG_W'(side0_r.cos_q);
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      ps_r   <= PROD_W'(dr_r) * PROD_W'(smag);
      pc_r   <= PROD_W'(dr_r) * PROD_W'(cmag);
      xneg_r <= side0_r.sin_q[TRIG_W-1];
      zneg_r <= !side0_r.cos_q[TRIG_W-1];
      dz1_r  <= side0_r.dz;
      y1_r   <= side0_r.y_q;
    end
  end

  // Stage 2: round Q.38 to Q.8, saturate, result register
  logic [PROD_W:0]    xrnd, zrnd;
  logic [COORD_W-1:0] x_nxt, z_nxt;
  logic [COORD_W-1:0] x_r, y_r, z_r;
  logic               dz_r;

  always_comb begin
    xrnd  = {1'b0, ps_r} + (PROD_W+1)'(64'd1 << 29);
    zrnd  = {1'b0, pc_r} + (PROD_W+1)'(64'd1 << 29);
    x_nxt = dz1_r ? '0 : sat24(xneg_r, MAG_W'(xrnd[PROD_W:30]));
    z_nxt = dz1_r ? '0 : sat24(zneg_r, MAG_W'(zrnd[PROD_W:30]));
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      x_r  <= x_nxt;
      y_r  <= y1_r;
      z_r  <= z_nxt;
      dz_r <= dz1_r;
    end
  end

  assign x_mm_q   = x_r;
  assign y_mm_q   = y_r;
  assign z_mm_q   = z_r;
  assign div_zero = dz_r;

endmodule

/* rtl/laser_line_triangulation.sv */
// Turns one detected laser point (column, row) and a turntable angle into a
// 3D point in Q15.8 mm. Fully pipelined: one beat in per cycle unless out_ready
// stalls it, through three front stages, a 17-stage one-bit-per-stage ratio divider
// and three multiply/round stages. Each stage advances when the next one is
// empty or moving, so bubbles close up under backpressure and in_ready drops
// only when every stage holds a beat. Write configuration only while the
// pipeline is empty; registers are read live by the stages.
module laser_line_triangulation #(
  parameter int ANGLE_STEPS = 360,
  parameter int COORD_BITS  = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] in_px_x,
  input  logic [COORD_BITS-1:0] in_px_y,
  input  logic [8:0]            in_angle_deg,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [23:0]           out_x_mm_q,
  output logic [23:0]           out_y_mm_q,
  output logic [23:0]           out_z_mm_q,
  output logic                  out_div_zero,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_idx,
  input  logic [17:0]           cfg_wdata
);
  import llt_pkg::*;

  localparam int DM_W  = COORD_BITS + SCALE_W;
  localparam int DEN_W = DM_W + 1;

  // Configuration registers
  logic [COORD_BITS-1:0] center_x_r, center_y_r, offset_px_r;
  logic [BASE_W-1:0]     baseline_r;
  logic [DEPTH_W-1:0]    depth_r;
  logic [SCALE_W-1:0]    mmx_r, mmy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r  <= COORD_BITS'(320);
      center_y_r  <= COORD_BITS'(240);
      offset_px_r <= '0;
      baseline_r  <= '0;
      depth_r     <= '0;
      mmx_r       <= '0;
      mmy_r       <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_CENTER_X:   center_x_r  <= cfg_wdata[COORD_BITS-1:0];
        REG_CENTER_Y:   center_y_r  <= cfg_wdata[COORD_BITS-1:0];
        REG_OFFSET_PX:  offset_px_r <= cfg_wdata[COORD_BITS-1:0];
        REG_BASELINE:   baseline_r  <= cfg_wdata[BASE_W-1:0];
        REG_DEPTH:      depth_r     <= cfg_wdata[DEPTH_W-1:0];
        REG_MM_PER_PXX: mmx_r       <= cfg_wdata[SCALE_W-1:0];
        REG_MM_PER_PXY: mmy_r       <= cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage valids and load enables; a stage loads when empty or draining
  logic [NUM_STG-1:0] vld_r;
  logic [NUM_STG-1:0] ld;

  always_comb begin
    ld[NUM_STG-1] = !vld_r[NUM_STG-1] || out_ready;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      ld[k] = !vld_r[k] || ld[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ld[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < NUM_STG; k++) begin
        if (ld[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = vld_r[NUM_STG-1];

  // Datapath
  logic [DM_W-1:0]    diff_mm;
  logic [DEN_W-1:0]   den;
  side_t              side_f, side_d;
  logic [RATIO_W-1:0] ratio;

  llt_front #(
    .ANGLE_STEPS (ANGLE_STEPS),
    .COORD_BITS  (COORD_BITS)
  ) u_front (
    .clk           (clk),
    .ld            (ld[FRONT_STG-1:0]),
    .px_x          (in_px_x),
    .px_y          (in_px_y),
    .angle_deg     (in_angle_deg),
    .center_x      (center_x_r),
    .center_y      (center_y_r),
    .offset_px     (offset_px_r),
    .baseline_mm_q (baseline_r),
    .mm_per_px_x   (mmx_r),
    .mm_per_px_y   (mmy_r),
    .diff_mm       (diff_mm),
    .den           (den),
    .side          (side_f)
  );

  llt_div #(
    .COORD_BITS (COORD_BITS)
  ) u_div (
    .clk      (clk),
    .ld       (ld[FRONT_STG+DIV_STG-1:FRONT_STG]),
    .diff_mm  (diff_mm),
    .den      (den),
    .side_in  (side_f),
    .ratio    (ratio),
    .side_out (side_d)
  );

  llt_back u_back (
    .clk        (clk),
    .ld         (ld[NUM_STG-1:FRONT_STG+DIV_STG]),
    .ratio      (ratio),
    .side_in    (side_d),
    .depth_mm_q (depth_r),
    .x_mm_q     (out_x_mm_q),
    .y_mm_q     (out_y_mm_q),
    .z_mm_q     (out_z_mm_q),
    .div_zero   (out_div_zero)
  );

  // A zero denominator forces x and z to zero
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_div_zero) |-> (out_x_mm_q == '0 && out_z_mm_q == '0))
    else $error("div_zero beat with nonzero x or z");

  // Input stalls only when the output is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output backpressure");

  // A full pipeline with a draining output must accept again
  a_full_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |-> in_ready)
    else $error("output draining but input not ready");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
  import llt_pkg::*;

  localparam int N_RANDOM  = 800;
  localparam int WD_LIMIT  = 20000;
  localparam int DRAIN_CYC = 40;

  // expected 3D point
  typedef struct {
    logic [23:0] x;
    logic [23:0] y;
    logic [23:0] z;
    logic        dz;
  } point_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [11:0] in_px_x;
  logic [11:0] in_px_y;
  logic [8:0]  in_angle_deg;
  logic        out_valid;
  logic        out_ready;
  logic [23:0] out_x_mm_q;
  logic [23:0] out_y_mm_q;
  logic [23:0] out_z_mm_q;
  logic        out_div_zero;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [17:0] cfg_wdata;

  // predictor's copy of the registers
  logic [11:0] m_cx, m_cy, m_off;
  logic [15:0] m_base, m_sx, m_sy;
  logic [17:0] m_depth;

  int  n_fail;
  int  idle_cnt;
  bit  no_idle;
  bit  hold_rx;
  int  n_beats_in;
  int  n_points;
  int  n_dz;

  laser_line_triangulation u_top (.*);

  // sine of a turn fraction, signed Q1.14, truncated Taylor series
  function automatic int unsigned_sin(input logic [31:0] fin);
    bit                neg;
    logic [31:0]       f;
    longint unsigned   x, x2, t;
    longint            s;
    longint            q;
    f   = fin;
    neg = 0;
    if (f >= 32'h8000_0000) begin
      neg = 1;
      f   = f - 32'h8000_0000;
    end
    if (f > 32'h4000_0000) f = 32'h8000_0000 - f;
    x  = (longint'(f) * 64'd3373259426) >> 31;
    x2 = (x * x) >> 30;
    t  = x;
    s  = longint'(x);
    for (int k = 1; k <= 4; k++) begin
      t = ((t * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) s = s - longint'(t);
      else s = s + longint'(t);
    end
    if (s < 0) s = 0;
    q = (s + 32768) >>> 16;
    if (q > 16384) q = 16384;
    return neg ? -int'(q) : int'(q);
  endfunction

  function automatic logic [23:0] clip24(input bit neg, input longint unsigned mag);
    if (mag == 0) return 24'd0;
    if (neg) return (mag > 64'd8388608) ? 24'h80_0000 : 24'(-longint'(mag));
    return (mag > 64'd8388607) ? 24'h7F_FFFF : 24'(mag);
  endfunction

  function automatic logic [23:0] axis_q8(input longint unsigned dr, input int trig,
                                          input bit negate);
    bit              neg;
    longint unsigned mag, p;
    neg = trig < 0;
    mag = neg ? longint'(-trig) : longint'(trig);
    p   = (dr * mag + (64'd1 << 29)) >> 30;
    return clip24(neg ^ negate, p);
  endfunction

  function automatic point_t triangulate(input logic [11:0] px, input logic [11:0] py,
                                         input logic [8:0] ang_in);
    point_t          r;
    int unsigned     ang, dx, diff;
    longint unsigned diff_mm, den, dy, ratio, dr;
    logic [31:0]     frac;
    bit              yneg;
    ang     = ang_in % 360;
    dx      = (px >= m_cx) ? px - m_cx : m_cx - px;
    diff    = (dx > m_off) ? dx - m_off : 0;
    diff_mm = longint'(diff) * m_sx;
    den     = (longint'(m_base) << 8) + diff_mm;
    yneg    = py > m_cy;
    dy      = yneg ? py - m_cy : m_cy - py;
    r.y     = clip24(yneg, (dy * m_sy + 128) >> 8);
    if (den == 0) begin
      r.x  = '0;
      r.z  = '0;
      r.dz = 1'b1;
    end else begin
      ratio = (diff_mm << 16) / den;
      dr    = longint'(m_depth) * ratio;
      frac  = 32'((longint'(ang) << 32) / 360);
      r.x   = axis_q8(dr, unsigned_sin(frac), 1'b0);
      r.z   = axis_q8(dr, unsigned_sin(frac + 32'h4000_0000), 1'b1);
      r.dz  = 1'b0;
    end
    return r;
  endfunction

  // in-order store of predicted points
  class point_board;
    point_t pending[$];

    function void note_beat(input logic [11:0] px, input logic [11:0] py,
                            input logic [8:0] ang);
      pending.insert(pending.size(), triangulate(px, py, ang));
    endfunction

    function void check_point(input logic [23:0] x, input logic [23:0] y,
                              input logic [23:0] z, input logic dz);
      point_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected point x=%h y=%h z=%h dz=%b", $time, x, y, z, dz);
        n_fail++;
        return;
      end
      e = pending.pop_front();
      if (x !== e.x) begin
        $display("%0t: x mismatch exp %h got %h", $time, e.x, x);
        n_fail++;
      end
      if (y !== e.y) begin
        $display("%0t: y mismatch exp %h got %h", $time, e.y, y);
        n_fail++;
      end
      if (z !== e.z) begin
        $display("%0t: z mismatch exp %h got %h", $time, e.z, z);
        n_fail++;
      end
      if (dz !== e.dz) begin
        $display("%0t: div_zero mismatch exp %b got %b", $time, e.dz, dz);
        n_fail++;
      end
    endfunction
  endclass

  point_board board;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // monitor: sample at rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        board.note_beat(in_px_x, in_px_y, in_angle_deg);
        n_beats_in++;
      end
      if (out_valid && out_ready) begin
        board.check_point(out_x_mm_q, out_y_mm_q, out_z_mm_q, out_div_zero);
        n_points++;
        if (out_div_zero) n_dz++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (!in_valid && board.pending.size() == 0)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WD_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, long hold when asked
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        out_ready <= 1'b0;
        repeat (60) @(negedge clk);
        hold_rx = 0;
      end
      if (!no_idle && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 12);
        out_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic cfg_write(input cfg_idx_t idx, input logic [17:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_CENTER_X:   m_cx    = val[11:0];
      REG_CENTER_Y:   m_cy    = val[11:0];
      REG_OFFSET_PX:  m_off   = val[11:0];
      REG_BASELINE:   m_base  = val[15:0];
      REG_DEPTH:      m_depth = val[17:0];
      REG_MM_PER_PXX: m_sx    = val[15:0];
      REG_MM_PER_PXY: m_sy    = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic cfg_all(input logic [11:0] cx, input logic [11:0] cy,
                         input logic [11:0] off, input logic [15:0] base,
                         input logic [17:0] depth, input logic [15:0] sx,
                         input logic [15:0] sy);
    cfg_write(REG_CENTER_X, 18'(cx));
    cfg_write(REG_CENTER_Y, 18'(cy));
    cfg_write(REG_OFFSET_PX, 18'(off));
    cfg_write(REG_BASELINE, 18'(base));
    cfg_write(REG_DEPTH, depth);
    cfg_write(REG_MM_PER_PXX, 18'(sx));
    cfg_write(REG_MM_PER_PXY, 18'(sy));
  endtask

  // one beat; called at a falling edge, returns at a falling edge
  task automatic send_point(input logic [11:0] px, input logic [11:0] py,
                            input logic [8:0] ang);
    int gap;
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_px_x      <= px;
    in_px_y      <= py;
    in_angle_deg <= ang;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  task automatic random_points(input int n);
    logic [11:0] px, py;
    for (int i = 0; i < n; i++) begin
      // mostly near the centre, some anywhere
      if ($urandom_range(0, 3) == 0) begin
        px = 12'($urandom);
        py = 12'($urandom);
      end else begin
        px = 12'(int'(m_cx) + $urandom_range(0, 400) - 200);
        py = 12'(int'(m_cy) + $urandom_range(0, 400) - 200);
      end
      send_point(px, py, 9'($urandom_range(0, 511)));
    end
  endtask

  initial begin
    board      = new();
    n_fail     = 0;
    idle_cnt   = 0;
    no_idle    = 0;
    hold_rx    = 0;
    n_beats_in = 0;
    n_points   = 0;
    n_dz       = 0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_px_x      = '0;
    in_px_y      = '0;
    in_angle_deg = '0;
    cfg_we       = 1'b0;
    cfg_idx      = REG_CENTER_X;
    cfg_wdata    = '0;
    m_cx = 12'd320; m_cy = 12'd240; m_off = '0;
    m_base = '0; m_depth = '0; m_sx = '0; m_sy = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values: every point has a zero denominator
    send_point(12'd0, 12'd0, 9'd0);
    send_point(12'd4095, 12'd4095, 9'd511);
    drain();

    // typical scanner setup; directed angles and extremes
    cfg_all(12'd320, 12'd240, 12'd10, 16'd25600, 18'd76800, 16'd800, 16'd800);
    send_point(12'd420, 12'd100, 9'd0);
    send_point(12'd420, 12'd100, 9'd90);
    send_point(12'd420, 12'd100, 9'd180);
    send_point(12'd420, 12'd100, 9'd270);
    send_point(12'd200, 12'd380, 9'd45);
    send_point(12'd325, 12'd240, 9'd10);      // offset beyond distance
    send_point(12'd320, 12'd240, 9'd359);
    send_point(12'd4095, 12'd0, 9'd360);      // angle wraps
    send_point(12'd0, 12'd4095, 9'd511);
    send_point(12'hAAA, 12'h555, 9'h155);
    send_point(12'h555, 12'hAAA, 9'h0AA);
    drain();

    // extremes: saturation both ways
    cfg_all(12'd0, 12'd4095, 12'd0, 16'd0, 18'h3FFFF, 16'hFFFF, 16'hFFFF);
    send_point(12'd4095, 12'd0, 9'd90);
    send_point(12'd4095, 12'd4095, 9'd270);
    send_point(12'd1, 12'd0, 9'd180);
    send_point(12'd0, 12'd0, 9'd0);           // zero diff, zero baseline
    drain();

    cfg_all(12'd4095, 12'd0, 12'd4095, 16'hFFFF, 18'd1, 16'd1, 16'd1);
    send_point(12'd0, 12'd4095, 9'd30);
    send_point(12'd4095, 12'd0, 9'd300);
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      cfg_all(12'($urandom_range(100, 900)), 12'($urandom_range(100, 700)),
              12'($urandom_range(0, 60)), 16'($urandom),
              18'($urandom), 16'($urandom), 16'($urandom));
      if (ph == 2) hold_rx = 1;   // receiver holds off, pipeline fills
      random_points(N_RANDOM / 8);
      drain();                    // sender pauses until all points are back
    end
    drain();

    // last part: no idling on either side
    cfg_all(12'd640, 12'd480, 12'd5, 16'd12800, 18'd51200, 16'd1200, 16'd1500);
    no_idle = 1;
    random_points(N_RANDOM / 4);
    drain();

    $display("Covered %0d points in, %0d out (%0d with zero denominator),",
             n_beats_in, n_points, n_dz);
    $display("over extreme and random register settings with stalls.");
    if (n_fail == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
